@@ rtl/odws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odws_pkg
// shared codes, field widths and the command struct for the deque cells
// ----------------------------------------------------------------------------
package odws_pkg;

	localparam int unsigned ACTION_W = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned OCC_W    = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_REMOVE     = 3'd4,
		ACT_FIND       = 3'd5
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic go;
		logic shift_in;
		logic load_tail;
		logic shift_out;
		logic remove;
	} cell_cmd_t;

endpackage

@@ rtl/odws_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odws_req_if / odws_rsp_if
// valid/ready channels for request and response beats
// ----------------------------------------------------------------------------
interface odws_req_if;
	logic                     valid;
	logic                     ready;
	logic [2:0]               action;
	logic [31:0]              item_value;

	modport source (output valid, output action, output item_value, input ready);
	modport sink (input valid, input action, input item_value, output ready);
endinterface

interface odws_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic                     found;
	logic [4:0]               occupancy;

	modport source (output valid, output status, output found, output occupancy, input ready);
	modport sink (input valid, input status, input found, input occupancy, output ready);
endinterface

@@ rtl/ordered_deque_with_search.sv @@
`timescale 1ns / 1ps
// response: registered, valid in the cycle after the request beat is taken
// throughput: one request per cycle unless an untaken response holds it;
//   DEPTH-cell first-match ripple plus the shift select sets the clock period
// reset: arst_n clears the entry count and the response valid; entry
//   contents stay undefined and are never read above the count
// ----------------------------------------------------------------------------
// ordered_deque_with_search
// bounded deque with remove-by-value and find, built as a row of cells
// ----------------------------------------------------------------------------
module ordered_deque_with_search
	import odws_pkg::*;
#(
	parameter int unsigned DEPTH      = 16,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	odws_req_if.sink    req,
	odws_rsp_if.source  rsp
);

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic                  go;
	logic [DATA_WIDTH-1:0] value;
	logic [DATA_WIDTH+VALUE_W-1:0] value_ext;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cnt_next;
	logic [CW+OCC_W-1:0]   cnt_ext;
	logic                  full;
	logic                  empty;
	logic                  hit;
	status_t               status_next;
	logic                  found_next;
	cell_cmd_t             cmd;
	action_t               act;

	logic                  rsp_valid_q;
	status_t               status_q;
	logic                  found_q;
	logic [OCC_W-1:0]      occ_q;

	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DEPTH:0]        match_chain;

	assign go        = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign value_ext = {{DATA_WIDTH{1'b0}}, req.item_value};
	assign value     = value_ext[DATA_WIDTH-1:0];
	assign act       = action_t'(req.action);
	assign full      = (cnt_q == CW'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign match_chain[0] = 1'b0;
	assign hit       = match_chain[DEPTH];

	always_comb begin
		cmd         = '0;
		cmd.go      = go;
		cnt_next    = cnt_q;
		status_next = ST_DONE;
		found_next  = 1'b0;
		case (act)
			ACT_PUSH_FRONT: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					cmd.shift_in = 1'b1;
					cnt_next     = cnt_q + 1'b1;
				end
			end
			ACT_PUSH_BACK: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					cmd.load_tail = 1'b1;
					cnt_next      = cnt_q + 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					status_next = ST_EMPTY;
				end else begin
					cmd.shift_out = 1'b1;
					cnt_next      = cnt_q - 1'b1;
				end
			end
			ACT_POP_BACK: begin
				if (empty) begin
					status_next = ST_EMPTY;
				end else begin
					cnt_next = cnt_q - 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (hit) begin
					cmd.remove = 1'b1;
					found_next = 1'b1;
					cnt_next   = cnt_q - 1'b1;
				end else begin
					status_next = ST_NOT_FOUND;
				end
			end
			ACT_FIND: begin
				if (hit) begin
					found_next = 1'b1;
				end else begin
					status_next = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	assign cnt_ext = {{OCC_W{1'b0}}, cnt_next};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_data;
		logic [DATA_WIDTH-1:0] right_data;

		if (i == 0) begin : g_head
			assign left_data = value;
		end else begin : g_body
			assign left_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data = cell_data[i];
		end else begin : g_inner
			assign right_data = cell_data[i+1];
		end

		odws_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.value      (value),
			.occupied   (CW'(i) < cnt_q),
			.at_tail    (CW'(i) == cnt_q),
			.left_data  (left_data),
			.right_data (right_data),
			.match_in   (match_chain[i]),
			.match_out  (match_chain[i+1]),
			.data       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (go) begin
				cnt_q       <= cnt_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response beat payload
	always_ff @(posedge clk) begin
		if (go) begin
			status_q <= status_next;
			found_q  <= found_next;
			occ_q    <= cnt_ext[OCC_W-1:0];
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.found     = found_q;
	assign rsp.occupancy = occ_q;

endmodule

@@ rtl/odws_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odws_cell
// one list position: holds an entry, compares it, shifts with its neighbors
// ----------------------------------------------------------------------------
module odws_cell
	import odws_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  cell_cmd_t             cmd,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic                  occupied,
	input  logic                  at_tail,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic [DATA_WIDTH-1:0] right_data,
	input  logic                  match_in,
	output logic                  match_out,
	output logic [DATA_WIDTH-1:0] data
);

	logic [DATA_WIDTH-1:0] data_q;

	assign match_out = match_in | (occupied && (data_q == value));
	assign data      = data_q;

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			if (cmd.shift_in) begin
				data_q <= left_data;
			end else if (cmd.load_tail && at_tail) begin
				data_q <= value;
			end else if (cmd.shift_out || (cmd.remove && match_out)) begin
				data_q <= right_data;
			end
		end
	end

endmodule

@@ bench/deque_result_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_result_check
// watches the request and response channels of the deque, keeps its own copy
// of the ordered list, predicts status, found flag and occupancy for every
// request beat and compares each response beat against the oldest prediction
// ----------------------------------------------------------------------------
module deque_result_check
	import odws_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	odws_req_if   req,
	odws_rsp_if   rsp,
	output int    mismatches,
	output int    beats_checked
);

	typedef struct packed {
		status_t            status;
		logic               found;
		logic [OCC_W-1:0]   occupancy;
	} deque_result_t;

	logic [VALUE_W-1:0] slots [DEPTH];
	int                 held;
	deque_result_t      expected_results [$];
	deque_result_t      want;
	int                 errs;

	function automatic deque_result_t apply_request(logic [ACTION_W-1:0] act,
			logic [VALUE_W-1:0] value);
		deque_result_t res;
		int            hit;
		int            i;
		res.status = ST_DONE;
		res.found  = 1'b0;
		hit = -1;
		for (i = 0; i < held; i++) begin
			if (hit < 0 && slots[i] == value) begin
				hit = i;
			end
		end
		case (act)
			ACT_PUSH_FRONT: begin
				if (held >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (i = held; i > 0; i--) begin
						slots[i] = slots[i-1];
					end
					slots[0] = value;
					held++;
				end
			end
			ACT_PUSH_BACK: begin
				if (held >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					slots[held] = value;
					held++;
				end
			end
			ACT_POP_FRONT: begin
				if (held == 0) begin
					res.status = ST_EMPTY;
				end else begin
					for (i = 1; i < held; i++) begin
						slots[i-1] = slots[i];
					end
					held--;
				end
			end
			ACT_POP_BACK: begin
				if (held == 0) begin
					res.status = ST_EMPTY;
				end else begin
					held--;
				end
			end
			ACT_REMOVE: begin
				if (hit < 0) begin
					res.status = ST_NOT_FOUND;
				end else begin
					for (i = hit + 1; i < held; i++) begin
						slots[i-1] = slots[i];
					end
					held--;
					res.found = 1'b1;
				end
			end
			ACT_FIND: begin
				if (hit < 0) begin
					res.status = ST_NOT_FOUND;
				end else begin
					res.found = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.occupancy = held[OCC_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			expected_results.delete();
			mismatches    <= 0;
			beats_checked <= 0;
		end else begin
			errs = 0;
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t response beat with nothing expected: status %0d found %0d occ %0d",
						$time, rsp.status, rsp.found, rsp.occupancy);
					errs++;
				end else begin
					want = expected_results[0];
					expected_results.delete(0);
					if (rsp.status !== want.status) begin
						$display("%0t status mismatch: expected %0d, got %0d",
							$time, want.status, rsp.status);
						errs++;
					end
					if (rsp.found !== want.found) begin
						$display("%0t found mismatch: expected %0d, got %0d",
							$time, want.found, rsp.found);
						errs++;
					end
					if (rsp.occupancy !== want.occupancy) begin
						$display("%0t occupancy mismatch: expected %0d, got %0d",
							$time, want.occupancy, rsp.occupancy);
						errs++;
					end
					beats_checked <= beats_checked + 1;
				end
			end
			if (req.valid && req.ready) begin
				expected_results = {expected_results,
					apply_request(req.action, req.item_value)};
			end
			mismatches <= mismatches + errs;
		end
	end

endmodule

@@ bench/tb_ordered_deque_with_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_deque_with_search
// drives push, pop, remove, find and unused action beats into the deque through directed
// corner cases and biased random traffic under several idle and stall mixes;
// the result checker beside the block does the prediction and comparison
// ----------------------------------------------------------------------------
module tb_ordered_deque_with_search;
	import odws_pkg::*;

	localparam int DEPTH          = 16;
	localparam int RANDOM_BEATS   = 280;
	localparam int MODE_SPAN      = 48;
	localparam int RECENT_MAX     = 24;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int   idle_pct     = 0;
	int   stall_pct    = 0;
	int   sent_beats   = 0;
	int   quiet_cycles = 0;
	int   mismatches;
	int   beats_checked;
	logic grow_mode    = 1'b1;

	logic [VALUE_W-1:0] pushed_values [$];

	odws_req_if req_ch ();
	odws_rsp_if rsp_ch ();

	ordered_deque_with_search #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (VALUE_W)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	deque_result_check #(
		.DEPTH (DEPTH)
	) result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.mismatches    (mismatches),
		.beats_checked (beats_checked)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_beat(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] value);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= act;
		req_ch.item_value <= value;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		sent_beats++;
		if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
			pushed_values = {pushed_values, value};
			if (pushed_values.size() > RECENT_MAX) begin
				pushed_values.delete(0);
			end
		end
	endtask

	// sender holds off until every response is back
	task automatic wait_drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (beats_checked != sent_beats) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(4))
			0: v = VALUE_W'($urandom_range(7));
			1: v = (pushed_values.size() > 0) ?
				pushed_values[$urandom_range(pushed_values.size() - 1)] : $urandom();
			2: v = $urandom_range(1) ? {VALUE_W{1'b1}} : {VALUE_W{1'b0}};
			3: v = {{(VALUE_W-1){1'b0}}, 1'b1} << $urandom_range(VALUE_W - 1);
			default: v = $urandom();
		endcase
		return v;
	endfunction

	task automatic send_random_beat();
		int                  r;
		logic [ACTION_W-1:0] act;
		r = $urandom_range(99);
		if (r < (grow_mode ? 30 : 12)) begin
			act = ACT_PUSH_FRONT;
		end else if (r < (grow_mode ? 60 : 24)) begin
			act = ACT_PUSH_BACK;
		end else if (r < (grow_mode ? 68 : 46)) begin
			act = ACT_POP_FRONT;
		end else if (r < (grow_mode ? 76 : 68)) begin
			act = ACT_POP_BACK;
		end else if (r < 84) begin
			act = ACT_REMOVE;
		end else if (r < 96) begin
			act = ACT_FIND;
		end else begin
			act = $urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B;
		end
		send_beat(act, pick_value());
	endtask

	task automatic run_phase(int sender_idle, int receiver_stall);
		int n;
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		grow_mode = $urandom_range(1);
		for (n = 0; n < RANDOM_BEATS; n++) begin
			if (n % MODE_SPAN == MODE_SPAN - 1) begin
				grow_mode = ~grow_mode;
			end
			send_random_beat();
		end
		wait_drain();
	endtask

	initial begin
		int k;
		req_ch.valid      <= 1'b0;
		req_ch.action     <= ACT_PUSH_FRONT;
		req_ch.item_value <= {VALUE_W{1'b0}};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		send_beat(ACT_POP_FRONT, $urandom());
		send_beat(ACT_POP_BACK, $urandom());
		send_beat(ACT_FIND, {VALUE_W{1'b0}});

		// fill to depth with extremes and repeated values
		send_beat(ACT_PUSH_BACK, {VALUE_W{1'b0}});
		send_beat(ACT_PUSH_FRONT, {VALUE_W{1'b1}});
		for (k = 0; k < DEPTH - 2; k++) begin
			if (k % 2 == 0) begin
				send_beat(ACT_PUSH_BACK, VALUE_W'(5));
			end else begin
				send_beat(ACT_PUSH_FRONT, {1'b1, {(VALUE_W-1){1'b0}}} >> k);
			end
		end

		// full list corner cases
		send_beat(ACT_PUSH_FRONT, $urandom());
		send_beat(ACT_PUSH_BACK, $urandom());
		send_beat(ACT_SPARE_A, $urandom());
		send_beat(ACT_FIND, VALUE_W'(5));
		send_beat(ACT_REMOVE, VALUE_W'(5));
		send_beat(ACT_REMOVE, 32'h1234_5678);
		send_beat(ACT_POP_FRONT, $urandom());
		send_beat(ACT_POP_BACK, $urandom());
		wait_drain();

		run_phase(0, 0);
		run_phase(75, 0);
		run_phase(0, 75);
		run_phase(32, 32);

		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
